FILE: src/gdh_pkg.sv
// Shared types and constants for the grid distance heuristic block.
package gdh_pkg;

  localparam int OUT_W    = 19;
  localparam int RAD_W    = 2 * OUT_W;
  localparam int ROOT_W   = OUT_W;
  localparam int OCT_FRAC = 8;
  localparam int MODE_W   = 2;

  localparam logic [OUT_W-1:0] OUT_MAX  = '1;
  localparam logic [7:0]       OCT_COEF = 8'd150;

  typedef enum logic [MODE_W-1:0] {
    MODE_MANHATTAN = 2'd0,
    MODE_OCTILE    = 2'd1,
    MODE_EUCLIDEAN = 2'd2,
    MODE_CHEBYSHEV = 2'd3
  } mode_t;

endpackage

FILE: src/grid_distance_heuristic.sv
// Top level: pipelined grid distance heuristic (Manhattan, octile, Euclidean, Chebyshev).
// Pipeline from start to done: differences, min/max and squares, radicand, square root stages, output register.
// Throughput: one transaction per cycle; the square root takes two result bits per stage.
// busy is high only while rst is high; results cannot be stalled.
// Reset clears all stage valid bits and sets the mode register to Manhattan.
module grid_distance_heuristic #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [COORD_BITS-1:0]     src_x,
  input  logic [COORD_BITS-1:0]     src_y,
  input  logic [COORD_BITS-1:0]     dst_x,
  input  logic [COORD_BITS-1:0]     dst_y,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [gdh_pkg::MODE_W-1:0] heuristic_mode,
  output logic                      done,
  output logic [gdh_pkg::OUT_W-1:0] heuristic_value
);
  import gdh_pkg::*;

  localparam int ITERS   = 2;
  localparam int NSQ     = (ROOT_W + ITERS - 1) / ITERS;
  localparam int LAT     = 3 + NSQ + 1;
  localparam int COEF_W  = COORD_BITS + 8;
  localparam int SQ_W    = 2 * COORD_BITS + 1;
  localparam int WW      = COORD_BITS + FRAC_BITS + 9 + OUT_W;
  localparam int EXT_W   = SQ_W + 2 * FRAC_BITS + RAD_W;
  localparam int SAT_SH  = RAD_W - 2 * FRAC_BITS;
  localparam int OCT_SHL = (FRAC_BITS >= OCT_FRAC) ? FRAC_BITS - OCT_FRAC : 0;
  localparam int OCT_SHR = (FRAC_BITS < OCT_FRAC) ? OCT_FRAC - FRAC_BITS : 0;

  mode_t hmode;
  logic  accept;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      hmode <= MODE_MANHATTAN;
    end else if (cfg_valid && cfg_ready) begin
      hmode <= mode_t'(heuristic_mode);
    end
  end

  // Stage 1: absolute differences
  logic                  s1_vld;
  mode_t                 s1_mode;
  logic [COORD_BITS-1:0] s1_dx, s1_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode <= hmode;
    s1_dx   <= (dst_x >= src_x) ? dst_x - src_x : src_x - dst_x;
    s1_dy   <= (dst_y >= src_y) ? dst_y - src_y : src_y - dst_y;
  end

  // Stage 2: min, max, sum, squares, octile correction
  logic                    s2_vld;
  mode_t                   s2_mode;
  logic [COORD_BITS-1:0]   s2_hi;
  logic [COORD_BITS:0]     s2_sum;
  logic [COEF_W-1:0]       s2_coef;
  logic [2*COORD_BITS-1:0] s2_dxx, s2_dyy;
  logic [COORD_BITS-1:0]   s1_lo, s1_hi;

  assign s1_lo = (s1_dx < s1_dy) ? s1_dx : s1_dy;
  assign s1_hi = (s1_dx < s1_dy) ? s1_dy : s1_dx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_mode <= s1_mode;
    s2_hi   <= s1_hi;
    s2_sum  <= {1'b0, s1_dx} + {1'b0, s1_dy};
    s2_coef <= COEF_W'(s1_lo) * COEF_W'(OCT_COEF);
    s2_dxx  <= (2*COORD_BITS)'(s1_dx) * (2*COORD_BITS)'(s1_dx);
    s2_dyy  <= (2*COORD_BITS)'(s1_dy) * (2*COORD_BITS)'(s1_dy);
  end

  // Stage 3: direct results and square root radicand
  logic [WW-1:0]    wide;
  logic [OUT_W-1:0] simple;
  logic [SQ_W-1:0]  sq_sum;
  logic [EXT_W-1:0] rad_ext;

  always_comb begin
    case (s2_mode)
      MODE_MANHATTAN: wide = WW'(s2_sum) << FRAC_BITS;
      MODE_OCTILE:    wide = (((WW'(s2_sum) << OCT_FRAC) - WW'(s2_coef)) << OCT_SHL) >> OCT_SHR;
      MODE_CHEBYSHEV: wide = WW'(s2_hi) << FRAC_BITS;
      default:        wide = '0;
    endcase
    simple  = (wide > WW'(OUT_MAX)) ? OUT_MAX : wide[OUT_W-1:0];
    sq_sum  = SQ_W'(s2_dxx) + SQ_W'(s2_dyy);
    rad_ext = EXT_W'(sq_sum) << (2 * FRAC_BITS);
  end

  logic             sq_vld    [0:NSQ];
  mode_t            sq_mode   [0:NSQ];
  logic             sq_sat    [0:NSQ];
  logic [OUT_W-1:0] sq_simple [0:NSQ];
  logic [RAD_W-1:0] sq_v      [0:NSQ];
  logic [RAD_W-1:0] sq_root   [0:NSQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else begin
      sq_vld[0] <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    sq_mode[0]   <= s2_mode;
    sq_sat[0]    <= (sq_sum >> SAT_SH) != '0;
    sq_simple[0] <= simple;
    sq_v[0]      <= rad_ext[RAD_W-1:0];
    sq_root[0]   <= '0;
  end

  // Square root stages: restoring digit-by-digit, two result bits per stage
  for (genvar s = 0; s < NSQ; s++) begin : g_sqrt
    logic [RAD_W-1:0] v_next, root_next;

    always_comb begin
      logic [RAD_W-1:0] v;
      logic [RAD_W-1:0] r;
      logic [RAD_W-1:0] b;
      int               k;
      v = sq_v[s];
      r = sq_root[s];
      b = '0;
      k = 0;
      for (int j = 0; j < ITERS; j++) begin
        k = s * ITERS + j;
        if (k < ROOT_W) begin
          b = RAD_W'(1) << (2 * (ROOT_W - 1 - k));
          if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
        end
      end
      v_next    = v;
      root_next = r;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[s+1] <= 1'b0;
      end else begin
        sq_vld[s+1] <= sq_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      sq_mode[s+1]   <= sq_mode[s];
      sq_sat[s+1]    <= sq_sat[s];
      sq_simple[s+1] <= sq_simple[s];
      sq_v[s+1]      <= v_next;
      sq_root[s+1]   <= root_next;
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq_vld[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (sq_mode[NSQ] == MODE_EUCLIDEAN) begin
      heuristic_value <= sq_sat[NSQ] ? OUT_MAX : sq_root[NSQ][OUT_W-1:0];
    end else begin
      heuristic_value <= sq_simple[NSQ];
    end
  end

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching transaction");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("transaction lost in pipeline");

  a_root_fits: assert property (@(posedge clk) disable iff (rst)
    (sq_vld[NSQ] && !sq_sat[NSQ]) |-> (sq_root[NSQ] >> ROOT_W) == '0)
    else $error("square root exceeds output width");

endmodule
